// File: src/nmea_tde_pkg.sv
package nmea_tde_pkg;

  // Result status codes; the error codes are listed lowest value first in priority of reporting.
  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_START  = 3'd1,
    STATUS_BAD_TYPE   = 3'd2,
    STATUS_FEW_TOKENS = 3'd3,
    STATUS_BAD_NUMBER = 3'd4
  } status_e;

  localparam int unsigned StatusW = 3;
  localparam int unsigned TwoDigW = 7;
  localparam int unsigned YearW   = 14;

  // One parsed sentence as handed from the parser to the output register.
  typedef struct packed {
    status_e              status;
    logic [TwoDigW-1:0]   hour;
    logic [TwoDigW-1:0]   minute;
    logic [TwoDigW-1:0]   second;
    logic [TwoDigW-1:0]   day;
    logic [TwoDigW-1:0]   month;
    logic [YearW-1:0]     year;
  } result_t;

endpackage

// File: src/nmea_tde_parser.sv
module nmea_tde_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  output logic                  res_valid_o,
  output nmea_tde_pkg::result_t res_o
);

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RMC  = 2'd1,
    KIND_ZDA  = 2'd2
  } kind_e;

  localparam logic [7:0]  CharDollar = 8'h24;
  localparam logic [7:0]  CharComma  = 8'h2C;
  localparam logic [7:0]  CharZero   = 8'h30;
  localparam logic [7:0]  CharNine   = 8'h39;
  localparam logic [23:0] TagRmc     = 24'h524D43;
  localparam logic [23:0] TagZda     = 24'h5A4441;
  localparam logic [2:0]  FldHour    = 3'd0;
  localparam logic [2:0]  FldMinute  = 3'd1;
  localparam logic [2:0]  FldSecond  = 3'd2;
  localparam logic [2:0]  FldDay     = 3'd3;
  localparam logic [2:0]  FldMonth   = 3'd4;
  localparam logic [2:0]  FldYear    = 3'd5;
  localparam logic [3:0]  TokType    = 4'd0;
  localparam logic [3:0]  TokTime    = 4'd1;
  localparam logic [3:0]  TokZdaDay  = 4'd2;
  localparam logic [3:0]  TokZdaYear = 4'd4;
  localparam logic [3:0]  TokRmcDate = 4'd9;
  localparam logic [3:0]  TokMax     = 4'd15;
  localparam logic [2:0]  PosMax     = 3'd7;
  localparam logic [2:0]  PosLimit   = 3'd6;
  localparam logic [4:0]  NeedRmc    = 5'd10;
  localparam logic [4:0]  NeedZda    = 5'd5;
  localparam logic [16:0] LimTwoDig  = 17'd99;
  localparam logic [16:0] LimYear    = 17'd9999;
  localparam logic [13:0] RmcEpoch   = 14'd2000;

  localparam int unsigned TwoDigW = nmea_tde_pkg::TwoDigW;
  localparam int unsigned YearW   = nmea_tde_pkg::YearW;

  logic               awaiting_q, awaiting_nx, awaiting_d;
  logic               start_bad_q, start_bad_nx, start_bad_d;
  logic [3:0]         tok_q, tok_nx, tok_d;
  logic               prev_comma_q, prev_comma_nx, prev_comma_d;
  logic [15:0]        type_hist_q, type_hist_nx, type_hist_d;
  kind_e              kind_q, kind_nx, kind_d;
  logic [2:0]         pos_q, pos_nx, pos_d;
  logic [TwoDigW-1:0] hour_q, hour_nx, hour_d;
  logic [TwoDigW-1:0] minute_q, minute_nx, minute_d;
  logic [TwoDigW-1:0] second_q, second_nx, second_d;
  logic [TwoDigW-1:0] day_q, day_nx, day_d;
  logic [TwoDigW-1:0] month_q, month_nx, month_d;
  logic [YearW-1:0]   year_q, year_nx, year_d;
  logic [5:0]         seen_q, seen_nx, seen_d;
  logic [5:0]         stopped_q, stopped_nx, stopped_d;

  logic               is_digit;
  logic [3:0]         digit;
  logic [23:0]        window;
  logic               pos_mode, whole_mode;
  logic [2:0]         fld;
  logic [5:0]         fld_bit;
  logic [YearW-1:0]   cur;
  logic [16:0]        scaled;
  logic [16:0]        lim;
  logic               upd_en;
  logic [YearW-1:0]   upd_val;
  logic [4:0]         count;
  logic [4:0]         need;
  nmea_tde_pkg::result_t res;

  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);
  assign digit    = char_i[3:0];
  assign window   = {type_hist_q, char_i};

  // Which accumulator this byte feeds, if any.
  always_comb begin
    pos_mode   = 1'b0;
    whole_mode = 1'b0;
    fld        = FldHour;
    if (char_i != CharComma) begin
      if (tok_q == TokTime) begin
        pos_mode = pos_q < PosLimit;
        fld      = FldHour + {1'b0, pos_q[2:1]};
      end else if ((kind_q == KIND_RMC) && (tok_q == TokRmcDate)) begin
        pos_mode = pos_q < PosLimit;
        fld      = FldDay + {1'b0, pos_q[2:1]};
      end else if ((kind_q == KIND_ZDA) && (tok_q >= TokZdaDay) && (tok_q <= TokZdaYear)) begin
        whole_mode = 1'b1;
        fld        = tok_q[2:0] + 3'd1;
      end
    end
  end

  assign fld_bit = 6'd1 << fld;
  assign lim     = (tok_q == TokZdaYear) ? LimYear : LimTwoDig;

  always_comb begin
    unique case (fld)
      FldHour:   cur = {{(YearW-TwoDigW){1'b0}}, hour_q};
      FldMinute: cur = {{(YearW-TwoDigW){1'b0}}, minute_q};
      FldSecond: cur = {{(YearW-TwoDigW){1'b0}}, second_q};
      FldDay:    cur = {{(YearW-TwoDigW){1'b0}}, day_q};
      FldMonth:  cur = {{(YearW-TwoDigW){1'b0}}, month_q};
      default:   cur = year_q;
    endcase
  end

  // Multiply by ten as two shifts and an add, and add the new digit.
  assign scaled = {cur, 3'b000} + {2'b00, cur, 1'b0} + {13'd0, digit};

  // Digit accumulation for the selected field.
  always_comb begin
    upd_en     = 1'b0;
    upd_val    = cur;
    seen_nx    = seen_q;
    stopped_nx = stopped_q;
    if (accept_i && pos_mode) begin
      if (!pos_q[0]) begin
        if (is_digit) begin
          seen_nx = seen_q | fld_bit;
          upd_en  = 1'b1;
          upd_val = {{(YearW-4){1'b0}}, digit};
        end else begin
          stopped_nx = stopped_q | fld_bit;
        end
      end else if (is_digit && ((seen_q & fld_bit) != '0) && ((stopped_q & fld_bit) == '0)) begin
        upd_en  = 1'b1;
        upd_val = scaled[YearW-1:0];
      end
    end else if (accept_i && whole_mode && ((stopped_q & fld_bit) == '0)) begin
      if (is_digit) begin
        seen_nx = seen_q | fld_bit;
        upd_en  = 1'b1;
        upd_val = (scaled > lim) ? lim[YearW-1:0] : scaled[YearW-1:0];
      end else begin
        stopped_nx = stopped_q | fld_bit;
      end
    end
  end

  always_comb begin
    hour_nx   = hour_q;
    minute_nx = minute_q;
    second_nx = second_q;
    day_nx    = day_q;
    month_nx  = month_q;
    year_nx   = year_q;
    if (upd_en) begin
      unique case (fld)
        FldHour:   hour_nx   = upd_val[TwoDigW-1:0];
        FldMinute: minute_nx = upd_val[TwoDigW-1:0];
        FldSecond: second_nx = upd_val[TwoDigW-1:0];
        FldDay:    day_nx    = upd_val[TwoDigW-1:0];
        FldMonth:  month_nx  = upd_val[TwoDigW-1:0];
        default:   year_nx   = upd_val;
      endcase
    end
  end

  // Tokenizer and sentence type detection.
  always_comb begin
    awaiting_nx   = awaiting_q;
    start_bad_nx  = start_bad_q;
    tok_nx        = tok_q;
    prev_comma_nx = prev_comma_q;
    type_hist_nx  = type_hist_q;
    kind_nx       = kind_q;
    pos_nx        = pos_q;
    if (accept_i) begin
      if (awaiting_q) begin
        start_bad_nx = char_i != CharDollar;
        awaiting_nx  = 1'b0;
      end
      if (char_i == CharComma) begin
        if (tok_q < TokMax) begin
          tok_nx = tok_q + 4'd1;
        end
        pos_nx        = '0;
        prev_comma_nx = 1'b1;
      end else begin
        if (tok_q == TokType) begin
          if (window == TagRmc) begin
            kind_nx = KIND_RMC;
          end else if ((window == TagZda) && (kind_q != KIND_RMC)) begin
            kind_nx = KIND_ZDA;
          end
          type_hist_nx = window[15:0];
        end
        if (pos_q < PosMax) begin
          pos_nx = pos_q + 3'd1;
        end
        prev_comma_nx = 1'b0;
      end
    end
  end

  // Judgement of the finished sentence, from the state after its last byte.
  assign count = {1'b0, tok_nx} + {4'd0, !prev_comma_nx};
  assign need  = (kind_nx == KIND_RMC) ? NeedRmc : NeedZda;

  always_comb begin
    res = '0;
    priority if (start_bad_nx) begin
      res.status = nmea_tde_pkg::STATUS_BAD_START;
    end else if (kind_nx == KIND_NONE) begin
      res.status = nmea_tde_pkg::STATUS_BAD_TYPE;
    end else if (count < need) begin
      res.status = nmea_tde_pkg::STATUS_FEW_TOKENS;
    end else if (seen_nx != 6'h3F) begin
      res.status = nmea_tde_pkg::STATUS_BAD_NUMBER;
    end else begin
      res.status = nmea_tde_pkg::STATUS_OK;
      res.hour   = hour_nx;
      res.minute = minute_nx;
      res.second = second_nx;
      res.day    = day_nx;
      res.month  = month_nx;
      res.year   = (kind_nx == KIND_RMC) ? year_nx + RmcEpoch : year_nx;
    end
  end

  assign res_valid_o = accept_i && last_i;
  assign res_o       = res;

  // The last byte returns the parser to its reset state.
  always_comb begin
    if (accept_i && last_i) begin
      awaiting_d   = 1'b1;
      start_bad_d  = 1'b0;
      tok_d        = '0;
      prev_comma_d = 1'b0;
      type_hist_d  = '0;
      kind_d       = KIND_NONE;
      pos_d        = '0;
      hour_d       = '0;
      minute_d     = '0;
      second_d     = '0;
      day_d        = '0;
      month_d      = '0;
      year_d       = '0;
      seen_d       = '0;
      stopped_d    = '0;
    end else begin
      awaiting_d   = awaiting_nx;
      start_bad_d  = start_bad_nx;
      tok_d        = tok_nx;
      prev_comma_d = prev_comma_nx;
      type_hist_d  = type_hist_nx;
      kind_d       = kind_nx;
      pos_d        = pos_nx;
      hour_d       = hour_nx;
      minute_d     = minute_nx;
      second_d     = second_nx;
      day_d        = day_nx;
      month_d      = month_nx;
      year_d       = year_nx;
      seen_d       = seen_nx;
      stopped_d    = stopped_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q   <= 1'b1;
      start_bad_q  <= 1'b0;
      tok_q        <= '0;
      prev_comma_q <= 1'b0;
      type_hist_q  <= '0;
      kind_q       <= KIND_NONE;
      pos_q        <= '0;
      hour_q       <= '0;
      minute_q     <= '0;
      second_q     <= '0;
      day_q        <= '0;
      month_q      <= '0;
      year_q       <= '0;
      seen_q       <= '0;
      stopped_q    <= '0;
    end else begin
      awaiting_q   <= awaiting_d;
      start_bad_q  <= start_bad_d;
      tok_q        <= tok_d;
      prev_comma_q <= prev_comma_d;
      type_hist_q  <= type_hist_d;
      kind_q       <= kind_d;
      pos_q        <= pos_d;
      hour_q       <= hour_d;
      minute_q     <= minute_d;
      second_q     <= second_d;
      day_q        <= day_d;
      month_q      <= month_d;
      year_q       <= year_d;
      seen_q       <= seen_d;
      stopped_q    <= stopped_d;
    end
  end

endmodule

// File: src/nmea_time_date_extractor.sv
// The result of a sentence is registered and is valid on the master side in the cycle
// after the transfer of its last byte.
// Throughput: one byte per cycle, sustained; the only limit is a result left waiting
// in the output register while the master side is stalled.
// Reset: rst_ni is asynchronous and active low; it clears the parser state and drops
// the output valid, so the next byte is taken as the start of a new sentence.
module nmea_time_date_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: one sentence byte per transfer.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  input  logic        s_axis_tlast_i,   // end_of_sentence
  // Master side: one result per sentence.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o    // [2:0] status, [9:3] hour, [16:10] minute,
                                        // [23:17] second, [30:24] day, [37:31] month,
                                        // [51:38] year, [55:52] zero
);

  logic                  accept;
  logic                  res_valid;
  nmea_tde_pkg::result_t res;
  nmea_tde_pkg::result_t out_q;
  logic                  out_valid_q;

  // The output register frees up in the same cycle that its result is taken, so a
  // byte can be accepted every cycle as long as the master side keeps up. Bytes
  // that are not the last of a sentence never produce a result, but they are still
  // held back while a result is stalled, which keeps the ready path simple.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // The parser keeps the per-sentence state: token position, sentence type and the
  // six field accumulators. It presents a result only on the last byte.
  nmea_tde_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register with valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The payload needs no reset; it is qualified by the valid bit.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.year, out_q.month, out_q.day, out_q.second,
                            out_q.minute, out_q.hour, out_q.status};

endmodule

// File: test/tb_nmea_time_date_extractor.sv
module tb_nmea_time_date_extractor;

  localparam logic [7:0]  CH_DOLLAR = 8'h24;
  localparam logic [7:0]  CH_COMMA  = 8'h2C;
  localparam logic [7:0]  CH_DOT    = 8'h2E;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [7:0]  CH_STAR   = 8'h2A;
  localparam logic [7:0]  CH_A      = 8'h41;
  localparam logic [23:0] TAG_RMC   = 24'h524D43;
  localparam logic [23:0] TAG_ZDA   = 24'h5A4441;

  // Accumulator slots, in the order the parser fills them.
  localparam int unsigned F_HOUR   = 0;
  localparam int unsigned F_MINUTE = 1;
  localparam int unsigned F_SECOND = 2;
  localparam int unsigned F_DAY    = 3;
  localparam int unsigned F_MONTH  = 4;
  localparam int unsigned F_YEAR   = 5;

  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 400_000;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RMC  = 2'd1,
    KIND_ZDA  = 2'd2
  } kind_e;

  // Tracks the parse of the byte stream and checks each returned time fix.
  class time_fix_board;
    nmea_tde_pkg::result_t fixes_due[$];
    int unsigned mismatches;

    bit          awaiting_first;
    bit          start_bad;
    logic [3:0]  tok_idx;
    bit          after_comma;
    logic [15:0] tag_hist;
    kind_e       kind;
    logic [2:0]  pos;
    int unsigned acc[6];
    logic [5:0]  seen;
    logic [5:0]  stopped;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      awaiting_first = 1'b1;
      start_bad      = 1'b0;
      tok_idx        = '0;
      after_comma    = 1'b0;
      tag_hist       = '0;
      kind           = KIND_NONE;
      pos            = '0;
      foreach (acc[i]) acc[i] = 0;
      seen           = '0;
      stopped        = '0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Token of three two-digit fields: characters 2k and 2k+1 feed field k.
    function void pair_char(int unsigned first_field, logic [2:0] p, logic [7:0] c);
      int unsigned f;
      if (p >= 3'd6) return;
      f = first_field + p / 2;
      if (!p[0]) begin
        if (is_digit(c)) begin
          seen[f] = 1'b1;
          acc[f]  = c - CH_ZERO;
        end else begin
          stopped[f] = 1'b1;
        end
      end else if (is_digit(c) && seen[f] && !stopped[f]) begin
        acc[f] = acc[f] * 10 + (c - CH_ZERO);
      end
    endfunction

    // Token that is one number: leading digits count, saturating at the limit.
    function void whole_char(int unsigned f, logic [7:0] c, int unsigned lim);
      int unsigned v;
      if (stopped[f]) return;
      if (is_digit(c)) begin
        seen[f] = 1'b1;
        v = acc[f] * 10 + (c - CH_ZERO);
        acc[f] = (v > lim) ? lim : v;
      end else begin
        stopped[f] = 1'b1;
      end
    endfunction

    function void take_byte(logic [7:0] c, logic last);
      logic [23:0] window;
      logic [4:0]  tally;
      nmea_tde_pkg::result_t fix;
      if (awaiting_first) begin
        start_bad      = (c != CH_DOLLAR);
        awaiting_first = 1'b0;
      end
      if (c == CH_COMMA) begin
        if (tok_idx != 4'd15) tok_idx++;
        pos         = '0;
        after_comma = 1'b1;
      end else begin
        if (tok_idx == 4'd0) begin
          window = {tag_hist, c};
          if (window == TAG_RMC) kind = KIND_RMC;
          else if (window == TAG_ZDA && kind != KIND_RMC) kind = KIND_ZDA;
          tag_hist = window[15:0];
        end else if (tok_idx == 4'd1) begin
          pair_char(F_HOUR, pos, c);
        end else if (kind == KIND_RMC && tok_idx == 4'd9) begin
          pair_char(F_DAY, pos, c);
        end else if (kind == KIND_ZDA && tok_idx >= 4'd2 && tok_idx <= 4'd4) begin
          whole_char(tok_idx + 1, c, (tok_idx == 4'd4) ? 9999 : 99);
        end
        if (pos != 3'd7) pos++;
        after_comma = 1'b0;
      end
      if (!last) return;

      tally = {1'b0, tok_idx} + (after_comma ? 5'd0 : 5'd1);
      fix   = '0;
      if (start_bad) fix.status = nmea_tde_pkg::STATUS_BAD_START;
      else if (kind == KIND_NONE) fix.status = nmea_tde_pkg::STATUS_BAD_TYPE;
      else if (tally < ((kind == KIND_RMC) ? 5'd10 : 5'd5)) begin
        fix.status = nmea_tde_pkg::STATUS_FEW_TOKENS;
      end
      else if (seen != 6'h3F) fix.status = nmea_tde_pkg::STATUS_BAD_NUMBER;
      else begin
        fix.status = nmea_tde_pkg::STATUS_OK;
        fix.hour   = nmea_tde_pkg::TwoDigW'(acc[F_HOUR]);
        fix.minute = nmea_tde_pkg::TwoDigW'(acc[F_MINUTE]);
        fix.second = nmea_tde_pkg::TwoDigW'(acc[F_SECOND]);
        fix.day    = nmea_tde_pkg::TwoDigW'(acc[F_DAY]);
        fix.month  = nmea_tde_pkg::TwoDigW'(acc[F_MONTH]);
        fix.year   = (kind == KIND_RMC) ? nmea_tde_pkg::YearW'(2000 + acc[F_YEAR])
                                        : nmea_tde_pkg::YearW'(acc[F_YEAR]);
      end
      fixes_due = {fixes_due, fix};
      clear();
    endfunction

    function void compare(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_fix(logic [55:0] d);
      nmea_tde_pkg::result_t want;
      if (fixes_due.size() == 0) begin
        $display("%0t: result with no sentence pending, expected none, got %h", $time, d);
        mismatches++;
        return;
      end
      want = fixes_due.pop_front();
      compare("status", want.status, d[2:0]);
      compare("hour", want.hour, d[9:3]);
      compare("minute", want.minute, d[16:10]);
      compare("second", want.second, d[23:17]);
      compare("day", want.day, d[30:24]);
      compare("month", want.month, d[37:31]);
      compare("year", want.year, d[51:38]);
      compare("padding", 0, d[55:52]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;

  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  logic [7:0]    line_q[$];
  time_fix_board board;

  nmea_time_date_extractor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Both sides are observed at the edge where the transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) board.take_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) board.check_fix(m_axis_tdata_o);
    end
  end

  initial begin
    #(8 * LIMIT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  function automatic void put_byte(logic [7:0] b);
    line_q = {line_q, b};
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_q = {line_q, s[i]};
  endfunction

  // Digits with an occasional arbitrary byte mixed in.
  function automatic void put_digits(int unsigned n, int unsigned junk_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < junk_pct) put_byte(8'($urandom_range(255)));
      else put_byte(8'(CH_ZERO + $urandom_range(9)));
    end
  endfunction

  function automatic void put_time();
    put_digits(($urandom_range(99) < 85) ? 6 : $urandom_range(8), 4);
    if ($urandom_range(99) < 40) begin
      put_byte(CH_DOT);
      put_digits(2, 0);
    end
  endfunction

  function automatic void put_talker();
    int unsigned n;
    n = ($urandom_range(99) < 90) ? 2 : $urandom_range(3);
    for (int unsigned i = 0; i < n; i++) put_byte(8'(CH_A + $urandom_range(25)));
  endfunction

  function automatic void put_filler();
    string pool;
    pool = ".0123456789ANSEWV";
    repeat ($urandom_range(6)) put_byte(pool[$urandom_range(pool.len() - 1)]);
  endfunction

  function automatic void put_checksum();
    string hex;
    hex = "0123456789ABCDEF";
    put_byte(CH_STAR);
    put_byte(hex[$urandom_range(15)]);
    put_byte(hex[$urandom_range(15)]);
  endfunction

  function automatic void put_rmc();
    put_byte(CH_DOLLAR);
    put_talker();
    put_text("RMC");
    put_byte(CH_COMMA);
    put_time();
    for (int k = 2; k <= 8; k++) begin
      put_byte(CH_COMMA);
      put_filler();
    end
    put_byte(CH_COMMA);
    put_digits(($urandom_range(99) < 85) ? 6 : $urandom_range(8), 4);
    // Mostly the usual tail, now and then enough tokens to saturate the count.
    repeat (($urandom_range(99) < 5) ? $urandom_range(6, 10) : $urandom_range(2)) begin
      put_byte(CH_COMMA);
      put_filler();
    end
    if ($urandom_range(1)) put_checksum();
  endfunction

  function automatic void put_zda();
    put_byte(CH_DOLLAR);
    put_talker();
    put_text("ZDA");
    put_byte(CH_COMMA);
    put_time();
    put_byte(CH_COMMA);
    put_digits(($urandom_range(99) < 80) ? 2 : $urandom_range(4), 4);
    put_byte(CH_COMMA);
    put_digits(($urandom_range(99) < 80) ? 2 : $urandom_range(4), 4);
    put_byte(CH_COMMA);
    put_digits(($urandom_range(99) < 80) ? 4 : $urandom_range(6), 4);
    if ($urandom_range(1)) put_text(",00,00");
    if ($urandom_range(1)) put_checksum();
  endfunction

  function automatic void put_random_sentence();
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(99);
    if (pick < 40) begin
      put_rmc();
    end else if (pick < 75) begin
      put_zda();
    end else if (pick < 88) begin
      // A well-formed sentence that is then damaged.
      if ($urandom_range(1)) put_rmc();
      else put_zda();
      case ($urandom_range(3))
        0: begin
          cut = $urandom_range(1, line_q.size());
          while (line_q.size() > cut) void'(line_q.pop_back());
        end
        1: line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
        2: put_byte(CH_COMMA);
        default: line_q[0] = 8'($urandom_range(255));
      endcase
    end else begin
      if ($urandom_range(1)) put_byte(CH_DOLLAR);
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_byte(logic [7:0] c, logic last);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic send_text(string s);
    put_text(s);
    send_line();
  endtask

  // Holds the stream off until every result owed has come back.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.fixes_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
    send_text("$GPZDA,201530.00,04,07,2002,00,00*60");
    send_text("GPRMC,123519,A,,,,,,,230394");
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M");
    send_text("$GPRMC,123519,A,,,,");
    send_text("$GPZDA,201530,04,07,");
    send_text("$GPZDA,201530,04,,2002");
    send_text("$GPZDA,A01530,04,07,2002");
    send_text("$GPZDA,2015,04,07,2002");
    send_text("$GPZDA,1:3/5:,01,01,1999");
    send_text("$GPZDA,995959,123,456,123456");
    send_text("$GPZDA,000000,7x,-3,2000");
    send_text("$GPZDA,000000, 7,03,+2000");
    send_text("$ZDARMC,000000,A,,,,,,,,010100");
    send_text("$RMCZDA,000000,A,,,,,,,,311299");
    send_text("$GPRMC,235959,A,,,,,,,,311299,,,,,,,,,,,,");
    send_text("$GPZDA,000000,00,00,0");
    send_text("$GPRMC,12345,A,,,,,,,,010203");
    send_text("$");
    send_text("X");
    send_text(",");
    // Bytes at both ends of the range inside the first token.
    put_byte(CH_DOLLAR);
    put_byte(8'hFF);
    put_byte(8'h00);
    send_text("RMC,010203,A,,,,,,,,040506");
  endtask

  initial begin
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    int unsigned phase_bytes;
    idle_plan  = '{0, 75, 0, 17};
    stall_plan = '{0, 0, 75, 17};
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      phase_bytes   = 0;
      while (phase_bytes < 30) begin
        put_random_sentence();
        phase_bytes += line_q.size();
        send_line();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.fixes_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
